// File: design/pip_pkg.sv
// ============================================================================
// pip_pkg: shared types and constants for the piecewise linear interpolator
// Breakpoint table geometry, command codes, controller states and the
// command/status bundles passed between controller and datapath.
// ============================================================================
package pip_pkg;

    localparam int MAX_POINTS = 16;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int DATA_W     = 16;
    localparam int CNT_W      = 5;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int DIV_STEPS  = PROD_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    // input item opcodes
    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_CONVERT = 1'b1;

    localparam logic [CNT_W-1:0] PC_RESET = CNT_W'(2);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHK_FIRST,
        ST_CHK_LAST,
        ST_SCAN,
        ST_PREP,
        ST_MUL,
        ST_DIV,
        ST_FIN
    } pip_state_t;

    typedef enum logic [1:0] {
        RES_LO,
        RES_HI,
        RES_INTERP
    } pip_res_sel_t;

    typedef struct packed {
        logic              wr_en;     // write one breakpoint
        logic              cap_in;    // capture value to convert
        logic [ADDR_W-1:0] rd_addr;   // table read address
        logic              set_lo;    // latch read entry as segment start
        logic              set_hi;    // latch read entry as segment end
        logic              prep;      // register dx, dy, span
        logic              mul;       // product into divider
        logic              div_step;  // one restoring divide step
        logic              load_res;  // write output register
        pip_res_sel_t      res_sel;
    } pip_cmd_t;

    typedef struct packed {
        logic              le_x;      // input <= X of read entry
        logic              ge_x;      // input >= X of read entry
        logic [ADDR_W-1:0] last_idx;  // index of last breakpoint in use
    } pip_sts_t;

endpackage

// File: design/pip_ctrl.sv
// ============================================================================
// pip_ctrl: sequencer for the piecewise linear interpolator
// Runs the end checks, the serial breakpoint search and the divide steps,
// and owns the input/output handshakes.
// ============================================================================
module pip_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_cmd,
    output logic              in_ready,
    input  logic              out_ready,
    output logic              out_valid,
    input  pip_pkg::pip_sts_t sts,
    output pip_pkg::pip_cmd_t ctl
);
    import pip_pkg::*;

    pip_state_t        state_reg, state_next;
    pip_res_sel_t      res_sel_reg, res_sel_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_sel_reg   <= RES_LO;
            idx_reg       <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_sel_reg   <= res_sel_next;
            idx_reg       <= idx_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        res_sel_next = res_sel_reg;
        idx_next     = idx_reg;
        step_next    = step_reg;
        in_ready     = 1'b0;
        ctl          = '0;
        ctl.res_sel  = res_sel_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                ctl.rd_addr = '0;
                if (in_valid)
                begin
                    if (in_cmd == CMD_LOAD)
                    begin
                        ctl.wr_en = 1'b1;
                    end
                    else
                    begin
                        ctl.cap_in = 1'b1;
                        state_next = ST_CHK_FIRST;
                    end
                end
            end
            ST_CHK_FIRST:
            begin
                // entry 0 on read data; start of first segment either way
                ctl.set_lo  = 1'b1;
                ctl.rd_addr = sts.last_idx;
                if (sts.le_x)
                begin
                    res_sel_next = RES_LO;
                    state_next   = ST_FIN;
                end
                else
                begin
                    state_next = ST_CHK_LAST;
                end
            end
            ST_CHK_LAST:
            begin
                ctl.rd_addr = ADDR_W'(1);
                idx_next    = ADDR_W'(1);
                if (sts.ge_x)
                begin
                    ctl.set_hi   = 1'b1;
                    res_sel_next = RES_HI;
                    state_next   = ST_FIN;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // input is below the last X, so the search ends by last_idx
                ctl.rd_addr = ADDR_W'(idx_reg + 1'b1);
                if (sts.le_x)
                begin
                    ctl.set_hi = 1'b1;
                    state_next = ST_PREP;
                end
                else
                begin
                    ctl.set_lo = 1'b1;
                    idx_next   = ADDR_W'(idx_reg + 1'b1);
                end
            end
            ST_PREP:
            begin
                ctl.prep   = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                ctl.mul    = 1'b1;
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                ctl.div_step = 1'b1;
                step_next    = STEP_W'(step_reg + 1'b1);
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    res_sel_next = RES_INTERP;
                    state_next   = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    ctl.load_res = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        if (ctl.load_res)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

    a_scan_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (idx_reg != '0 && idx_reg <= sts.last_idx))
        else $error("search index outside the active table");

    a_convert_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_cmd == CMD_CONVERT) |=> (state_reg == ST_CHK_FIRST))
        else $error("convert item did not start the end checks");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && step_reg == STEP_W'(DIV_STEPS - 1)) |=>
        (state_reg == ST_FIN && res_sel_reg == RES_INTERP))
        else $error("divider did not hand over after its last step");

    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load_res |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("result written without valid");

endmodule

// File: design/pip_dpath.sv
// ============================================================================
// pip_dpath: datapath for the piecewise linear interpolator
// Breakpoint memory, segment registers, 16x16 multiplier, restoring
// divider and the output register.
// ============================================================================
module pip_dpath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [pip_pkg::CNT_W-1:0]   cfg_wdata,
    input  logic                        cfg_we,
    input  logic [pip_pkg::ADDR_W-1:0]  point_index,
    input  logic [pip_pkg::DATA_W-1:0]  x_value,
    input  logic [pip_pkg::DATA_W-1:0]  y_value,
    input  pip_pkg::pip_cmd_t           ctl,
    output pip_pkg::pip_sts_t           sts,
    output logic [pip_pkg::DATA_W-1:0]  result
);
    import pip_pkg::*;

    logic [2*DATA_W-1:0] pt_mem [MAX_POINTS];
    logic [2*DATA_W-1:0] rd_data_reg;

    logic [CNT_W-1:0]  pc_reg;
    logic [DATA_W-1:0] in_reg;
    logic [DATA_W-1:0] x_lo_reg, y_lo_reg, x_hi_reg, y_hi_reg;
    logic [DATA_W-1:0] dx_reg, dy_reg, span_reg;
    logic              rising_reg, span_zero_reg;
    logic [PROD_W-1:0] quot_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] result_reg, result_next;

    logic [DATA_W-1:0] rd_x, rd_y;
    logic [DATA_W:0]   rem_sh, rem_diff;
    logic              q_bit;
    logic              rising;

    assign rd_x = rd_data_reg[2*DATA_W-1:DATA_W];
    assign rd_y = rd_data_reg[DATA_W-1:0];

    // breakpoint memory: {x, y} per slot
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            pt_mem[point_index] <= {x_value, y_value};
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= pt_mem[ctl.rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_RESET;
        end
        else if (cfg_we)
        begin
            pc_reg <= cfg_wdata;
        end
    end

    // compares against the read entry; clamp count to 1..MAX_POINTS, then last index
    always_comb
    begin
        sts.le_x = (in_reg <= rd_x);
        sts.ge_x = (in_reg >= rd_x);
        if (pc_reg == '0)
        begin
            sts.last_idx = '0;
        end
        else if (pc_reg > CNT_W'(MAX_POINTS))
        begin
            sts.last_idx = ADDR_W'(MAX_POINTS - 1);
        end
        else
        begin
            sts.last_idx = ADDR_W'(pc_reg - 1'b1);
        end
    end

    assign rising   = (y_lo_reg < y_hi_reg);
    assign rem_sh   = {rem_reg, quot_reg[PROD_W-1]};
    assign q_bit    = (rem_sh >= {1'b0, span_reg});
    assign rem_diff = rem_sh - {1'b0, span_reg};

    always_ff @(posedge clk)
    begin
        if (ctl.cap_in)
        begin
            in_reg <= x_value;
        end
        if (ctl.set_lo)
        begin
            x_lo_reg <= rd_x;
            y_lo_reg <= rd_y;
        end
        if (ctl.set_hi)
        begin
            x_hi_reg <= rd_x;
            y_hi_reg <= rd_y;
        end
        if (ctl.prep)
        begin
            dx_reg        <= in_reg - x_lo_reg;
            span_reg      <= x_hi_reg - x_lo_reg;
            span_zero_reg <= (x_hi_reg == x_lo_reg);
            rising_reg    <= rising;
            dy_reg        <= rising ? (y_hi_reg - y_lo_reg) : (y_lo_reg - y_hi_reg);
        end
        if (ctl.mul)
        begin
            quot_reg <= dx_reg * dy_reg;
            rem_reg  <= '0;
        end
        else if (ctl.div_step)
        begin
            quot_reg <= {quot_reg[PROD_W-2:0], q_bit};
            rem_reg  <= q_bit ? rem_diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
        end
        if (ctl.load_res)
        begin
            result_reg <= result_next;
        end
    end

    always_comb
    begin
        unique case (ctl.res_sel)
            RES_LO:
            begin
                result_next = y_lo_reg;
            end
            RES_HI:
            begin
                result_next = y_hi_reg;
            end
            RES_INTERP:
            begin
                if (span_zero_reg)
                begin
                    result_next = y_lo_reg;
                end
                else if (rising_reg)
                begin
                    result_next = y_lo_reg + quot_reg[DATA_W-1:0];
                end
                else
                begin
                    result_next = y_lo_reg - quot_reg[DATA_W-1:0];
                end
            end
            default:
            begin
                result_next = y_lo_reg;
            end
        endcase
    end

    assign result = result_reg;

endmodule

// File: design/piecewise_linear_interpolator.sv
// ============================================================================
// piecewise_linear_interpolator: characteristic-line lookup
// Holds up to 16 breakpoints (X, Y). Load items write one breakpoint,
// convert items map a 16-bit value through the line with saturation at
// both ends and truncating linear interpolation in between.
// ============================================================================
//
//  channel  handshake            payload                              dir
//  -------  -------------------  -----------------------------------  ---
//  in       in_valid / in_ready  cmd, point_index, x_value, y_value   in
//  out      out_valid/out_ready  result                               out
//  cfg      cfg_we               cfg_wdata (point_count)              in
//
//  Items are accepted only in idle, so one item is done before the next is
//  taken. A load writes its breakpoint and stays idle; a convert at or below
//  the first X or at or above the last X ends after the end checks, else the
//  search reads one table entry per cycle through the single memory read
//  port and the 32-step restoring divider takes one quotient bit
//  a cycle. Reset: async, active low; point_count returns to 2, table is not
//  cleared. A result waiting on out_ready does not block new items; only the
//  final write of the next convert waits for the output register to free up.
//
module piecewise_linear_interpolator (
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration
    input  logic                        cfg_we,
    input  logic [pip_pkg::CNT_W-1:0]   cfg_wdata,
    // input items
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        cmd,
    input  logic [pip_pkg::ADDR_W-1:0]  point_index,
    input  logic [pip_pkg::DATA_W-1:0]  x_value,
    input  logic [pip_pkg::DATA_W-1:0]  y_value,
    // result items
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [pip_pkg::DATA_W-1:0]  result
);
    import pip_pkg::*;

    pip_cmd_t ctl;   // controller -> datapath commands
    pip_sts_t sts;   // datapath -> controller compares, last table index

    // sequencer: end checks, serial search, divide steps, handshakes
    pip_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_cmd    (cmd),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .sts       (sts),
        .ctl       (ctl)
    );

    // table memory, segment regs, multiplier, divider, output register
    pip_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wdata   (cfg_wdata),
        .cfg_we      (cfg_we),
        .point_index (point_index),
        .x_value     (x_value),
        .y_value     (y_value),
        .ctl         (ctl),
        .sts         (sts),
        .result      (result)
    );

endmodule

// File: tb/sv/piecewise_linear_interpolator_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// piecewise_linear_interpolator_tb: self-checking testbench
// Sends load and convert items over the valid/ready input channel, takes
// each expected result from a behavioral model of the characteristic line
// or a hand-worked value, and checks every result in order. A short directed
// table comes first. Then random phases follow, each with a point-count
// write, bursty input, a stalling output side, and one long output hold-off.
// ============================================================================
module piecewise_linear_interpolator_tb;
    import pip_pkg::*;

    localparam int HALF_PERIOD   = 1;
    localparam int RESET_CYCLES  = 6;
    // room for any item still in flight, the longest convert included
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 90;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int DRAIN_LIMIT   = 4000;
    localparam int MAX_PRINTS    = 40;
    localparam int NUM_PHASES    = 9;

    // directed stimulus rows; a config row carries the new count in x
    typedef enum logic [1:0] {
        ROW_LOAD,
        ROW_CONV,
        ROW_CFG
    } row_kind_t;

    // table shapes used when a phase reloads the breakpoints
    typedef enum int {
        SHAPE_RISING,
        SHAPE_SCRAMBLED,
        SHAPE_REPEATS
    } shape_t;

    typedef struct packed {
        row_kind_t          kind;
        logic [ADDR_W-1:0]  idx;
        logic [DATA_W-1:0]  xv;
        logic [DATA_W-1:0]  yv;
        logic               typed;  // want holds a hand-worked result
        logic [DATA_W-1:0]  want;
    } dir_row_t;

    localparam int DIR_ROWS = 25;
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        // two points, rising segment
        '{ROW_LOAD, 4'd0, 16'h1000, 16'h0100, 1'b0, 16'h0000},
        '{ROW_LOAD, 4'd1, 16'hF000, 16'hFF00, 1'b0, 16'h0000},
        '{ROW_CONV, 4'd0, 16'h0000, 16'h5A5A, 1'b1, 16'h0100},  // below first X
        '{ROW_CONV, 4'd0, 16'h1000, 16'hA5A5, 1'b1, 16'h0100},  // at first X
        '{ROW_CONV, 4'd0, 16'hF000, 16'h5A5A, 1'b1, 16'hFF00},  // at last X
        '{ROW_CONV, 4'd0, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFF00},  // above last X
        '{ROW_CONV, 4'd0, 16'h8000, 16'h0000, 1'b0, 16'h0000},
        // falling segment
        '{ROW_LOAD, 4'd1, 16'hF000, 16'h0000, 1'b0, 16'h0000},
        '{ROW_CONV, 4'd0, 16'h8000, 16'h1234, 1'b0, 16'h0000},
        '{ROW_CONV, 4'd0, 16'h1001, 16'h0000, 1'b0, 16'h0000},
        // full-range segment, extremes of X and Y
        '{ROW_LOAD, 4'd0, 16'h0000, 16'hFFFF, 1'b0, 16'h0000},
        '{ROW_LOAD, 4'd1, 16'hFFFF, 16'h0000, 1'b0, 16'h0000},
        '{ROW_CONV, 4'd0, 16'h0001, 16'h0000, 1'b0, 16'h0000},
        '{ROW_CONV, 4'd0, 16'hFFFE, 16'h0000, 1'b0, 16'h0000},
        '{ROW_CONV, 4'd0, 16'h0000, 16'h0000, 1'b1, 16'hFFFF},
        '{ROW_CONV, 4'd0, 16'hFFFF, 16'h0000, 1'b1, 16'h0000},
        // single point: everything maps to the first Y
        '{ROW_CFG,  4'd0, 16'h0001, 16'h0000, 1'b0, 16'h0000},
        '{ROW_CONV, 4'd0, 16'h8000, 16'h0000, 1'b1, 16'hFFFF},
        '{ROW_CONV, 4'd0, 16'h0000, 16'h0000, 1'b1, 16'hFFFF},
        // count of zero acts as one
        '{ROW_CFG,  4'd0, 16'h0000, 16'h0000, 1'b0, 16'h0000},
        '{ROW_CONV, 4'd0, 16'h1234, 16'h0000, 1'b1, 16'hFFFF},
        // three points with X not increasing
        '{ROW_CFG,  4'd0, 16'h0003, 16'h0000, 1'b0, 16'h0000},
        '{ROW_LOAD, 4'd2, 16'h8000, 16'h4000, 1'b0, 16'h0000},
        '{ROW_CONV, 4'd0, 16'h9000, 16'h0000, 1'b1, 16'h4000},
        '{ROW_CONV, 4'd0, 16'h7000, 16'h0000, 1'b0, 16'h0000}
    };

    // DUT signals
    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [CNT_W-1:0]   cfg_wdata;
    logic               in_valid;
    logic               in_ready;
    logic               cmd;
    logic [ADDR_W-1:0]  point_index;
    logic [DATA_W-1:0]  x_value;
    logic [DATA_W-1:0]  y_value;
    logic               out_valid;
    logic               out_ready;
    logic [DATA_W-1:0]  result;

    // behavioral copy of the breakpoint table and count
    logic [DATA_W-1:0]  bp_x [MAX_POINTS];
    logic [DATA_W-1:0]  bp_y [MAX_POINTS];
    logic [CNT_W-1:0]   cur_count;

    // converted values still owed by the block, oldest first
    logic [DATA_W-1:0]  pending_results [$];
    logic [DATA_W-1:0]  oldest;

    int unsigned        cycle_count;
    int unsigned        mismatch_count;
    int unsigned        loads_sent;
    int unsigned        converts_sent;
    int unsigned        results_seen;
    int unsigned        count_writes;
    int unsigned        holds_done;
    bit                 hold_request;

    piecewise_linear_interpolator dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .point_index (point_index),
        .x_value     (x_value),
        .y_value     (y_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result      (result)
    );

    initial clk = 1'b0;
    always #HALF_PERIOD clk = ~clk;

    // Breakpoints actually in use: 0 acts as 1, anything past the table
    // size acts as the table size.
    function automatic int points_in_use();
        if (cur_count == 0)
            return 1;
        if (cur_count > MAX_POINTS)
            return MAX_POINTS;
        return int'(cur_count);
    endfunction

    // Value of the characteristic line at vin.
    function automatic logic [DATA_W-1:0] line_value(input logic [DATA_W-1:0] vin);
        int                 last;
        int                 k;
        logic [DATA_W-1:0]  y0;
        logic [DATA_W-1:0]  y1;
        logic [DATA_W-1:0]  dx16;
        logic [DATA_W-1:0]  span16;
        logic [PROD_W-1:0]  dy;
        logic [PROD_W-1:0]  acc;
        last = points_in_use() - 1;
        // saturate at both ends of the line
        if (vin <= bp_x[0])
            return bp_y[0];
        if (vin >= bp_x[last])
            return bp_y[last];
        // first breakpoint at or above the input ends the segment
        k = 1;
        while (k < last && vin > bp_x[k])
            k++;
        y0     = bp_y[k-1];
        y1     = bp_y[k];
        dx16   = vin - bp_x[k-1];
        span16 = bp_x[k] - bp_x[k-1];
        if (span16 == 0)
            return y0;
        if (y0 < y1)
        begin
            dy  = PROD_W'(y1 - y0);
            acc = (PROD_W'(dx16) * dy) / PROD_W'(span16);
            return y0 + acc[DATA_W-1:0];
        end
        dy  = PROD_W'(y0 - y1);
        acc = (PROD_W'(dx16) * dy) / PROD_W'(span16);
        return y0 - acc[DATA_W-1:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        if (mismatch_count < MAX_PRINTS)
            $display("%0t mismatch: %s: got %h, want %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Offer one item and hold it until accepted; the table copy and the
    // result queue follow the item at the edge where it is taken.
    task automatic push_item(input logic c, input logic [ADDR_W-1:0] idx,
                             input logic [DATA_W-1:0] xv, input logic [DATA_W-1:0] yv,
                             input logic typed, input logic [DATA_W-1:0] want);
        @(negedge clk);
        in_valid    <= 1'b1;
        cmd         <= c;
        point_index <= idx;
        x_value     <= xv;
        y_value     <= yv;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (c == CMD_LOAD)
        begin
            bp_x[idx] = xv;
            bp_y[idx] = yv;
            loads_sent++;
        end
        else
        begin
            pending_results.push_back(typed ? want : line_value(xv));
            converts_sent++;
        end
    endtask

    task automatic idle_cycles(input int n);
        repeat (n)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    // Sender stops and waits for every owed result, then lets in-flight
    // work (a trailing load or convert) finish before the register changes.
    task automatic settle();
        idle_cycles(1);
        while (pending_results.size() != 0)
            @(negedge clk);
        idle_cycles(SETTLE_CYCLES);
    endtask

    task automatic write_point_count(input logic [CNT_W-1:0] value);
        settle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        cur_count = value;
        count_writes++;
    endtask

    function automatic logic [DATA_W-1:0] pick_y();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 1) ? {DATA_W{1'b1}} : '0;
        return DATA_W'($urandom);
    endfunction

    // Rewrite every slot in use so no convert ever reads an unwritten entry.
    task automatic load_table(input shape_t shape);
        int used;
        int slot;
        int xv;
        int stepmax;
        used    = points_in_use();
        stepmax = 60000 / used;
        xv      = $urandom_range(0, 4000);
        for (slot = 0; slot < used; slot++)
        begin
            if (shape == SHAPE_SCRAMBLED)
                xv = $urandom_range(0, 65535);
            push_item(CMD_LOAD, ADDR_W'(slot), DATA_W'(xv), pick_y(), 1'b0, '0);
            if (shape != SHAPE_SCRAMBLED)
                xv = xv + $urandom_range(shape == SHAPE_REPEATS ? 0 : 1, stepmax);
        end
    endtask

    // Convert inputs lean toward the ends and the breakpoints themselves.
    function automatic logic [DATA_W-1:0] pick_convert_x();
        logic [DATA_W-1:0] v;
        int                choice;
        choice = $urandom_range(0, 9);
        if (choice == 0)
            return '0;
        if (choice == 1)
            return {DATA_W{1'b1}};
        if (choice <= 4)
        begin
            v = bp_x[$urandom_range(0, points_in_use() - 1)];
            v = v + DATA_W'($urandom_range(0, 2)) - DATA_W'(1);
            return v;
        end
        return DATA_W'($urandom);
    endfunction

    // One random phase: new count, fresh table, then bursts of mostly
    // converts with loads mixed in. With a hold-off the phase sends only
    // converts so the block backs up against the stalled output.
    task automatic run_phase(input logic [CNT_W-1:0] count, input shape_t shape,
                             input bit with_hold);
        int                burst_left;
        int                i;
        int                slot;
        logic [DATA_W-1:0] xv;
        write_point_count(count);
        load_table(shape);
        if (with_hold)
            hold_request = 1'b1;
        burst_left = 0;
        for (i = 0; i < PHASE_ITEMS; i++)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                if ($urandom_range(0, 3) != 0)
                    idle_cycles($urandom_range(1, 12));
            end
            burst_left--;
            if (with_hold || $urandom_range(0, 4) != 0)
            begin
                push_item(CMD_CONVERT, ADDR_W'($urandom), pick_convert_x(),
                          DATA_W'($urandom), 1'b0, '0);
            end
            else
            begin
                // loads may land on any slot; inside the used range they
                // mostly nudge a point, sometimes scramble it
                slot = $urandom_range(0, MAX_POINTS - 1);
                if ($urandom_range(0, 2) != 0)
                    xv = bp_x[slot] + DATA_W'($urandom_range(0, 16)) - DATA_W'(8);
                else
                    xv = DATA_W'($urandom);
                push_item(CMD_LOAD, ADDR_W'(slot), xv, pick_y(), 1'b0, '0);
            end
        end
    endtask

    // Output side: random modes of stalling, plus one long hold-off on request.
    initial
    begin : receiver
        int mode;
        int span_left;
        out_ready = 1'b0;
        mode      = 0;
        span_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(negedge clk);
                hold_request = 1'b0;
                holds_done++;
            end
            if (span_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                span_left = $urandom_range(50, 300);
            end
            span_left--;
            case (mode)
                0:
                begin
                    out_ready <= 1'b1;
                end
                1:
                begin
                    out_ready <= 1'($urandom_range(0, 1));
                end
                2:
                begin
                    out_ready <= (span_left % 4 == 0);
                end
                default:
                begin
                    out_ready <= ($urandom_range(0, 9) != 0);
                end
            endcase
        end
    end

    // Result checker: every accepted result against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("result with no convert pending", result, '0);
            end
            else
            begin
                oldest = pending_results.pop_front();
                results_seen++;
                if (result !== oldest)
                    report_mismatch("result", result, oldest);
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results owed", cycle_count,
                     pending_results.size());
            $display("[piecewise_linear_interpolator] ERROR");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [CNT_W-1:0] phase_counts [NUM_PHASES];
        shape_t           shape;
        int               r;
        int               p;
        int               wait_cycles;
        // the extremes, the out-of-range counts, and a few in between
        phase_counts = '{5'd16, 5'd1, 5'd2, 5'd0, 5'd31, 5'd5, 5'd8, 5'd12, 5'd16};
        phase_counts[7] = CNT_W'($urandom_range(3, 15));

        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        in_valid     = 1'b0;
        cmd          = CMD_LOAD;
        point_index  = '0;
        x_value      = '0;
        y_value      = '0;
        hold_request = 1'b0;
        cur_count    = PC_RESET;
        for (r = 0; r < MAX_POINTS; r++)
        begin
            bp_x[r] = '0;
            bp_y[r] = '0;
        end
        repeat (RESET_CYCLES)
            @(negedge clk);
        rst_n = 1'b1;

        // directed table
        for (r = 0; r < DIR_ROWS; r++)
        begin
            case (DIR_TABLE[r].kind)
                ROW_LOAD:
                begin
                    push_item(CMD_LOAD, DIR_TABLE[r].idx, DIR_TABLE[r].xv,
                              DIR_TABLE[r].yv, 1'b0, '0);
                end
                ROW_CONV:
                begin
                    push_item(CMD_CONVERT, DIR_TABLE[r].idx, DIR_TABLE[r].xv,
                              DIR_TABLE[r].yv, DIR_TABLE[r].typed, DIR_TABLE[r].want);
                end
                default:
                begin
                    write_point_count(DIR_TABLE[r].xv[CNT_W-1:0]);
                end
            endcase
        end

        // random phases; the first one carries the long output hold-off
        for (p = 0; p < NUM_PHASES; p++)
        begin
            if (p == 4 || p == 8)
                shape = SHAPE_SCRAMBLED;
            else if (p == 5)
                shape = SHAPE_REPEATS;
            else
                shape = shape_t'($urandom_range(0, 2));
            run_phase(phase_counts[p], shape, p == 0);
        end

        // drain: wait for owed results, then the block's own latency
        idle_cycles(1);
        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        while (pending_results.size() != 0)
            report_mismatch("convert without result", 'x, pending_results.pop_front());

        $display("run covered %0d loads and %0d converts (%0d results checked)",
                 loads_sent, converts_sent, results_seen);
        $display("over %0d point-count writes and %0d long output hold-off(s), %0d mismatches",
                 count_writes, holds_done, mismatch_count);
        if (mismatch_count == 0)
            $display("[piecewise_linear_interpolator] OK");
        else
            $display("[piecewise_linear_interpolator] ERROR");
        $finish;
    end

endmodule
